### src/sound_triggered_comet_renderer_defines.svh
// assertion macros for the comet renderer
// expects signals named clock and reset in the module that uses them
`ifndef SOUND_TRIGGERED_COMET_RENDERER_DEFINES_SVH
`define SOUND_TRIGGERED_COMET_RENDERER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define STCR_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stcr check failed");

// next-cycle implication, disabled during reset
`define STCR_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stcr check failed");

`endif

### src/stcr_pkg.sv
// shared types and constants for the comet renderer
// no dependencies
`timescale 1ns / 1ps

package stcr_pkg;

   localparam int STRIP_LENGTH_DEF = 30;
   localparam int SLOT_COUNT_DEF   = 15;
   localparam int TAIL_LENGTH_DEF  = 5;

   localparam int SAMPLE_W      = 10;
   localparam int TIME_W        = 32;
   localparam int CHAN_W        = 8;
   localparam int DEBOUNCE_W    = 16;
   localparam int PIXEL_INDEX_W = 5;
   localparam int FACTOR_W      = 17;
   localparam int FRAC_W        = 16;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SAMPLE_W-1:0]   THRESHOLD_RESET = 10'd500;
   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET  = 16'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_DEBOUNCE  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } colour_type;

endpackage

### src/sound_triggered_comet_renderer.sv
// channel  | signals                                  | contents
// req      | req_tvalid req_tready req_tdata          | one frame tick: sample, time, colour
// rsp      | rsp_tvalid rsp_tready rsp_tdata rsp_tlast| one pixel, tlast on the final pixel
// csr      | csr_we csr_index csr_wdata               | threshold and debounce writes
//
// one frame: the accept, then a walk over every slot in which an idle slot is only looked at and
// an active one draws min(TAIL_LENGTH, pos+1) pixels (a comet launched this frame draws at pos 0),
// then the STRIP_LENGTH pixels are read from the frame memory and emitted.
// the slot walk is set by the slot memory read and the one frame memory write port.
// after reset a pass over all STRIP_LENGTH entries zeroes the frame memory, req_tready stays low.
// rsp_tready low holds emission; emitted pixels are zeroed so the next frame starts blank.
// depends on stcr_pkg, stcr_ram, stcr_shade and the assertion macro header
`timescale 1ns / 1ps
`include "sound_triggered_comet_renderer_defines.svh"

module sound_triggered_comet_renderer
   import stcr_pkg::*;
#(
   parameter int STRIP_LENGTH = STRIP_LENGTH_DEF,
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int TAIL_LENGTH  = TAIL_LENGTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // sound_sample, now_ms, new_red, new_green, new_blue, zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // pixel_index, pixel_red, pixel_green, pixel_blue, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PW = $clog2(STRIP_LENGTH + TAIL_LENGTH + 1);
   localparam int FW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int JW = (TAIL_LENGTH > 1) ? $clog2(TAIL_LENGTH) : 1;

   localparam logic [PW-1:0] POS_STRIP = PW'(STRIP_LENGTH);
   localparam logic [PW-1:0] POS_END   = PW'(STRIP_LENGTH + TAIL_LENGTH);
   localparam logic [FW-1:0] PIX_LAST  = FW'(STRIP_LENGTH - 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);
   localparam logic [JW-1:0] TAIL_LAST = JW'(TAIL_LENGTH - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT,
      ST_DRAW,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [PW-1:0] pos;
      colour_type    colour;
   } slot_entry_type;

   localparam int SLOT_ENTRY_W = $bits(slot_entry_type);
   localparam int COLOUR_BITS  = $bits(colour_type);

   // input fields
   logic [SAMPLE_W-1:0] req_sample;
   logic [TIME_W-1:0]   req_now;
   colour_type          req_colour;

   assign req_sample       = req_tdata[9:0];
   assign req_now          = req_tdata[41:10];
   assign req_colour.red   = req_tdata[49:42];
   assign req_colour.green = req_tdata[57:50];
   assign req_colour.blue  = req_tdata[65:58];

   // registers
   state_type               state_ff, state_in;
   logic [SAMPLE_W-1:0]     thr_ff, thr_in;
   logic [DEBOUNCE_W-1:0]   deb_ff, deb_in;
   logic [TIME_W-1:0]       last_trig_ff, last_trig_in;
   logic                    launch_pend_ff, launch_pend_in;
   logic                    launching_ff, launching_in;
   colour_type              new_col_ff, new_col_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic [JW-1:0]           tail_ff, tail_in;
   logic [SLOT_COUNT-1:0]   active_ff, active_in;
   logic [FW-1:0]           rd_p_ff, rd_p_in;
   logic                    rd_busy_ff, rd_busy_in;
   logic [FW-1:0]           out_p_ff, out_p_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   colour_type              rsp_col_ff, rsp_col_in;
   logic                    rsp_last_ff, rsp_last_in;

   // memory ports
   logic                    slot_we;
   logic                    slot_re;
   slot_entry_type          slot_wdata;
   logic [SLOT_ENTRY_W-1:0] slot_rdata_raw;
   slot_entry_type          slot_rd;
   logic                    fr_we;
   logic [FW-1:0]           fr_waddr;
   colour_type              fr_wdata;
   logic                    fr_re;
   logic [COLOUR_BITS-1:0]  fr_rdata_raw;
   colour_type              fr_rdata;

   // draw datapath
   logic [PW-1:0]  eff_pos;
   colour_type     eff_col;
   logic [PW-1:0]  tail_ext;
   logic [PW-1:0]  pix_pos;
   logic [PW-1:0]  next_pos;
   logic           on_strip;
   logic           draw_end;
   colour_type     shade_col;
   logic [TIME_W-1:0] elapsed;
   logic           launch;

   // emit handshake
   logic           can_load;
   logic           issue;
   logic           load;

   assign slot_rd  = slot_entry_type'(slot_rdata_raw);
   assign fr_rdata = colour_type'(fr_rdata_raw);

   // a slot claimed this frame draws at position 0 with the new colour
   assign eff_pos  = launching_ff ? '0 : slot_rd.pos;
   assign eff_col  = launching_ff ? new_col_ff : slot_rd.colour;
   assign tail_ext = PW'(tail_ff);
   assign pix_pos  = eff_pos - tail_ext;
   assign next_pos = eff_pos + PW'(1);
   assign on_strip = pix_pos < POS_STRIP;
   assign draw_end = (tail_ff == TAIL_LAST) || (tail_ext == eff_pos);

   assign elapsed = req_now - last_trig_ff;
   assign launch  = (req_sample > thr_ff) && (elapsed >= TIME_W'(deb_ff));

   assign can_load = !rsp_valid_ff || rsp_tready;
   assign issue    = (state_ff == ST_EMIT) && rd_busy_ff && (!pend_ff || can_load);
   assign load     = (state_ff == ST_EMIT) && pend_ff && can_load;

   assign slot_wdata.pos    = next_pos;
   assign slot_wdata.colour = eff_col;

   stcr_shade #(
      .TAIL_LENGTH (TAIL_LENGTH),
      .JW          (JW)
   ) u_shade (
      .colour_in  (eff_col),
      .tail_idx   (tail_ff),
      .colour_out (shade_col)
   );

   stcr_ram #(
      .WIDTH (SLOT_ENTRY_W),
      .DEPTH (SLOT_COUNT),
      .AW    (SW)
   ) u_slot_mem (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_ff),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_ff),
      .rdata (slot_rdata_raw)
   );

   stcr_ram #(
      .WIDTH (COLOUR_BITS),
      .DEPTH (STRIP_LENGTH),
      .AW    (FW)
   ) u_frame_mem (
      .clock (clock),
      .we    (fr_we),
      .waddr (fr_waddr),
      .wdata (fr_wdata),
      .re    (fr_re),
      .raddr (rd_p_ff),
      .rdata (fr_rdata_raw)
   );

   always_comb begin
      state_in       = state_ff;
      thr_in         = thr_ff;
      deb_in         = deb_ff;
      last_trig_in   = last_trig_ff;
      launch_pend_in = launch_pend_ff;
      launching_in   = launching_ff;
      new_col_in     = new_col_ff;
      slot_in        = slot_ff;
      tail_in        = tail_ff;
      active_in      = active_ff;
      rd_p_in        = rd_p_ff;
      rd_busy_in     = rd_busy_ff;
      out_p_in       = out_p_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_last_in    = rsp_last_ff;
      slot_we        = 1'b0;
      slot_re        = 1'b0;
      fr_we          = 1'b0;
      fr_waddr       = pix_pos[FW-1:0];
      fr_wdata       = shade_col;
      fr_re          = 1'b0;

      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD: thr_in = csr_wdata[SAMPLE_W-1:0];
            CSR_DEBOUNCE:  deb_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            fr_we    = 1'b1;
            fr_waddr = rd_p_ff;
            fr_wdata = '0;
            if (rd_p_ff == PIX_LAST) begin
               rd_p_in  = '0;
               state_in = ST_IDLE;
            end else begin
               rd_p_in = rd_p_ff + FW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               launch_pend_in = launch;
               if (launch) begin
                  last_trig_in = req_now;
               end
               new_col_in = req_colour;
               slot_in    = '0;
               state_in   = ST_SLOT;
            end
         end
         ST_SLOT: begin
            slot_re = 1'b1;
            tail_in = '0;
            if (active_ff[slot_ff]) begin
               state_in = ST_DRAW;
            end else if (launch_pend_ff) begin
               // lowest free slot is the first free one met in the walk
               launching_in   = 1'b1;
               launch_pend_in = 1'b0;
               state_in       = ST_DRAW;
            end else if (slot_ff == SLOT_LAST) begin
               rd_p_in    = '0;
               rd_busy_in = 1'b1;
               pend_in    = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               slot_in = slot_ff + SW'(1);
            end
         end
         ST_DRAW: begin
            fr_we = on_strip;
            if (draw_end) begin
               slot_we            = 1'b1;
               active_in[slot_ff] = next_pos < POS_END;
               launching_in       = 1'b0;
               if (slot_ff == SLOT_LAST) begin
                  rd_p_in    = '0;
                  rd_busy_in = 1'b1;
                  pend_in    = 1'b0;
                  state_in   = ST_EMIT;
               end else begin
                  slot_in  = slot_ff + SW'(1);
                  state_in = ST_SLOT;
               end
            end else begin
               tail_in = tail_ff + JW'(1);
            end
         end
         ST_EMIT: begin
            // read each pixel once and zero it behind the read
            if (issue) begin
               fr_we    = 1'b1;
               fr_waddr = rd_p_ff;
               fr_wdata = '0;
               fr_re    = 1'b1;
               out_p_in = rd_p_ff;
               pend_in  = 1'b1;
               if (rd_p_ff == PIX_LAST) begin
                  rd_busy_in = 1'b0;
               end else begin
                  rd_p_in = rd_p_ff + FW'(1);
               end
            end else if (load) begin
               pend_in = 1'b0;
            end
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = PIXEL_INDEX_W'(out_p_ff);
               rsp_col_in   = fr_rdata;
               rsp_last_in  = out_p_ff == PIX_LAST;
               if (out_p_ff == PIX_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         thr_ff         <= THRESHOLD_RESET;
         deb_ff         <= DEBOUNCE_RESET;
         last_trig_ff   <= '0;
         launch_pend_ff <= 1'b0;
         launching_ff   <= 1'b0;
         active_ff      <= '0;
         rd_p_ff        <= '0;
         rd_busy_ff     <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         thr_ff         <= thr_in;
         deb_ff         <= deb_in;
         last_trig_ff   <= last_trig_in;
         launch_pend_ff <= launch_pend_in;
         launching_ff   <= launching_in;
         active_ff      <= active_in;
         rd_p_ff        <= rd_p_in;
         rd_busy_ff     <= rd_busy_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      new_col_ff   <= new_col_in;
      slot_ff      <= slot_in;
      tail_ff      <= tail_in;
      out_p_ff     <= out_p_in;
      rsp_index_ff <= rsp_index_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_col_ff.blue, rsp_col_ff.green, rsp_col_ff.red,
                        rsp_index_ff};

   `STCR_ASSERT_IMP(a_launch_into_free, (state_ff == ST_DRAW) && launching_ff, !active_ff[slot_ff])
   `STCR_ASSERT_NXT(a_accept_starts_walk, req_tvalid && req_tready, state_ff == ST_SLOT)
   `STCR_ASSERT_IMP(a_launch_from_accept, $rose(launch_pend_ff), $past(req_tvalid && req_tready))
   `STCR_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

### src/stcr_ram.sv
// simple dual-port synchronous memory, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module stcr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 30,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // a read and a write to the same entry return the old contents
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/stcr_shade.sv
// tail brightness: cubic falloff factor table and per-channel scaling
// depends on stcr_pkg
`timescale 1ns / 1ps

module stcr_shade
   import stcr_pkg::*;
#(
   parameter int TAIL_LENGTH = TAIL_LENGTH_DEF,
   parameter int JW          = 3
) (
   input  colour_type        colour_in,
   input  logic [JW-1:0]     tail_idx,
   output colour_type        colour_out
);

   localparam int PROD_W = CHAN_W + FACTOR_W;

   logic [FACTOR_W-1:0] factor_tab [TAIL_LENGTH];
   logic [FACTOR_W-1:0] factor;
   logic [PROD_W-1:0]   prod_red;
   logic [PROD_W-1:0]   prod_green;
   logic [PROD_W-1:0]   prod_blue;

   // q1.16 factor floor(65536 * (t-j)^3 / t^3), the head gets exactly 1.0
   for (genvar j = 0; j < TAIL_LENGTH; j++) begin : g_factor
      localparam longint REM = longint'(TAIL_LENGTH - j);
      localparam longint NUM = 64'd65536 * REM * REM * REM;
      localparam longint DEN = longint'(TAIL_LENGTH) * TAIL_LENGTH * TAIL_LENGTH;
      localparam longint FJ  = NUM / DEN;
      assign factor_tab[j] = FACTOR_W'(FJ);
   end

   assign factor     = factor_tab[tail_idx];
   assign prod_red   = PROD_W'(colour_in.red) * PROD_W'(factor);
   assign prod_green = PROD_W'(colour_in.green) * PROD_W'(factor);
   assign prod_blue  = PROD_W'(colour_in.blue) * PROD_W'(factor);

   assign colour_out.red   = prod_red[FRAC_W +: CHAN_W];
   assign colour_out.green = prod_green[FRAC_W +: CHAN_W];
   assign colour_out.blue  = prod_blue[FRAC_W +: CHAN_W];

endmodule
